// File: hdl/assert_macros.svh
// Assertion macros for the RTL; nttc_ctrl is the only file that includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define NTTC_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");
`define NTTC_NEVER(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("forbidden condition");
`else
`define NTTC_ASSERT(lbl, clk, rstn, prop)
`define NTTC_NEVER(lbl, clk, rstn, expr)
`endif
`endif

// File: hdl/nttc_pkg.sv
`timescale 1ns / 1ps
package nttc_pkg;
    localparam int NOTE_COUNT = 128;
    localparam int NOTE_W     = 7;
    localparam int OFS_W      = 14;
    localparam int DAC_W      = 12;
    localparam int DAC_MAX    = 4095;
    localparam int BASE_W     = 13;
    localparam int PROD_W     = 22;
    localparam int MAG_W      = 21;
    localparam int CNT_W      = 5;

    localparam logic [2:0] OP_NOTE   = 3'd0;
    localparam logic [2:0] OP_ADJUST = 3'd1;
    localparam logic [2:0] OP_INTERP = 3'd2;
    localparam logic [2:0] OP_CLEAR  = 3'd3;
    localparam logic [2:0] OP_BEND   = 3'd4;

    typedef logic [BASE_W-1:0] t_base_tab [NOTE_COUNT];

    // Rounded note * 4096 / 120, evaluated at elaboration only.
    function automatic t_base_tab f_base_tab();
        t_base_tab tab;
        for (int i = 0; i < NOTE_COUNT; i++) begin
            tab[i] = BASE_W'((i * (DAC_MAX + 1) * 2 + 120) / 240);
        end
        return tab;
    endfunction

    localparam t_base_tab BASE_TAB = f_base_tab();

    typedef struct packed {
        logic load;
        logic rd_note;
        logic rd_scan;
        logic exec;
        logic dn_init;
        logic up_init;
        logic scan_dec;
        logic scan_inc;
        logic cap_lo;
        logic cap_hi;
        logic mul;
        logic div_start;
        logic div_step;
        logic wr_interp;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic [2:0] op;
        logic       edge_note;
        logic       rd_nz;
        logic       scan_lo;
        logic       scan_hi;
        logic       div_last;
    } t_sts;
endpackage

// File: hdl/note_to_cv_tune_table.sv
// Note, adjust, clear, bend and unused opcodes pass through S_RD, S_EXEC and S_FIN after accept.
// Interpolate away from the edge notes also scans the table down and up for neighbors, multiplies
// and divides; its run time is set by the single table read port and the bit-serial divider.
// One item is in work at a time; a new beat is accepted the cycle after the previous result
// is loaded, so the block never takes a new item before the last one is through.
// Synchronous active-low reset clears the control state and marks every table entry zero.
`timescale 1ns / 1ps
module note_to_cv_tune_table
    import nttc_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [2:0]               i_opcode,
    input  logic [NOTE_W-1:0]        i_note_number,
    input  logic signed [15:0]       i_tune_delta,
    input  logic [13:0]              i_bend_amount,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [DAC_W-1:0]         o_dac_code,
    output logic signed [OFS_W-1:0]  o_tune_value
);
    t_cmd cmd;
    t_sts sts;

    nttc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    nttc_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_opcode      (i_opcode),
        .i_note_number (i_note_number),
        .i_tune_delta  (i_tune_delta),
        .i_bend_amount (i_bend_amount),
        .o_dac_code    (o_dac_code),
        .o_tune_value  (o_tune_value)
    );
endmodule

// File: hdl/nttc_dp.sv
`timescale 1ns / 1ps
module nttc_dp
    import nttc_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cmd                     i_cmd,
    output t_sts                     o_sts,
    input  logic [2:0]               i_opcode,
    input  logic [NOTE_W-1:0]        i_note_number,
    input  logic signed [15:0]       i_tune_delta,
    input  logic [13:0]              i_bend_amount,
    output logic [DAC_W-1:0]         o_dac_code,
    output logic signed [OFS_W-1:0]  o_tune_value
);
    logic [2:0]              r_op;
    logic [NOTE_W-1:0]       r_note;
    logic signed [15:0]      r_delta;
    logic [13:0]             r_bend;

    logic signed [OFS_W-1:0] mem [NOTE_COUNT];
    logic [NOTE_COUNT-1:0]   r_vld;
    logic signed [OFS_W-1:0] r_rd_raw;
    logic                    r_rd_v;
    logic signed [OFS_W-1:0] rd_val;
    logic [NOTE_W-1:0]       rd_addr;

    logic [NOTE_W-1:0]       r_scan;
    logic [NOTE_W-1:0]       r_n1, r_n2;
    logic signed [OFS_W-1:0] r_t1, r_t2;
    logic signed [PROD_W-1:0] r_prod;
    logic [NOTE_W-1:0]       r_x2;
    logic                    r_neg;
    logic [MAG_W-1:0]        r_quo;
    logic [NOTE_W-1:0]       r_rem;
    logic [CNT_W-1:0]        r_cnt;

    logic [DAC_W-1:0]        r_res_dac;
    logic signed [OFS_W-1:0] r_res_tune;
    logic [DAC_W-1:0]        r_out_dac;
    logic signed [OFS_W-1:0] r_out_tune;

    logic [BASE_W-1:0]       base;
    logic signed [15:0]      note_sum;
    logic signed [17:0]      adj_sum;
    logic signed [17:0]      ofs_sum;
    logic signed [14:0]      hi_ofs;
    logic signed [14:0]      lo_ofs;
    logic [DAC_W-1:0]        exec_dac;
    logic signed [OFS_W-1:0] exec_tune;
    logic                    exec_wr;

    logic signed [7:0]       x1;
    logic signed [14:0]      diff;
    logic [PROD_W-1:0]       prod_abs;
    logic [NOTE_W:0]         rem_sh;
    logic                    q_bit;
    logic signed [14:0]      q_sgn;
    logic signed [OFS_W-1:0] interp_val;

    logic                    wr_en;
    logic signed [OFS_W-1:0] wr_data;

    assign rd_addr = i_cmd.rd_scan ? r_scan : r_note;
    assign rd_val  = r_rd_v ? r_rd_raw : '0;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_opcode;
            r_note  <= i_note_number;
            r_delta <= i_tune_delta;
            r_bend  <= i_bend_amount;
        end
    end

    // Table memory: one write port at the addressed note, one registered read.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_note] <= wr_data;
        end
        if (i_cmd.rd_note || i_cmd.rd_scan) begin
            r_rd_raw <= mem[rd_addr];
        end
    end

    // An entry without its valid bit reads as zero, so clearing is immediate.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_rd_v <= 1'b0;
        end else begin
            if (i_cmd.exec && r_op == OP_CLEAR) begin
                r_vld <= '0;
            end else if (wr_en) begin
                r_vld[r_note] <= 1'b1;
            end
            if (i_cmd.rd_note || i_cmd.rd_scan) begin
                r_rd_v <= r_vld[rd_addr];
            end
        end
    end

    always_comb begin
        base     = BASE_TAB[r_note];
        note_sum = $signed({3'b000, base}) + $signed({{2{rd_val[OFS_W-1]}}, rd_val});
        ofs_sum  = $signed({{4{rd_val[OFS_W-1]}}, rd_val})
                 + $signed({{2{r_delta[15]}}, r_delta});
        adj_sum  = $signed({5'b00000, base}) + ofs_sum;
        hi_ofs   = 15'(DAC_MAX) - $signed({2'b00, base});
        lo_ofs   = 15'sd0 - $signed({2'b00, base});
        exec_dac  = '0;
        exec_tune = rd_val;
        exec_wr   = 1'b0;
        case (r_op)
            OP_NOTE: begin
                if (note_sum < 0) begin
                    exec_dac = '0;
                end else if (note_sum > 16'(DAC_MAX)) begin
                    exec_dac = DAC_W'(DAC_MAX);
                end else begin
                    exec_dac = note_sum[DAC_W-1:0];
                end
            end
            OP_ADJUST: begin
                exec_wr = 1'b1;
                if (adj_sum < 0) begin
                    exec_tune = lo_ofs[OFS_W-1:0];
                end else if (adj_sum > 18'(DAC_MAX)) begin
                    exec_tune = hi_ofs[OFS_W-1:0];
                end else begin
                    exec_tune = ofs_sum[OFS_W-1:0];
                end
            end
            OP_CLEAR: begin
                exec_tune = '0;
            end
            OP_BEND: begin
                exec_dac = r_bend[13:2];
            end
            default: begin
                exec_dac = '0;
            end
        endcase
    end

    // Interpolation datapath: neighbor scan, multiply, bit-serial divide.
    always_comb begin
        x1       = $signed({1'b0, r_note - r_n1});
        diff     = $signed({r_t2[OFS_W-1], r_t2}) - $signed({r_t1[OFS_W-1], r_t1});
        prod_abs = r_prod[PROD_W-1] ? PROD_W'(-r_prod) : r_prod;
        rem_sh   = {r_rem, r_quo[MAG_W-1]};
        q_bit    = (rem_sh >= {1'b0, r_x2});
        q_sgn    = r_neg ? -$signed(r_quo[14:0]) : $signed(r_quo[14:0]);
        interp_val = r_t1 + q_sgn[OFS_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.dn_init) begin
            r_scan <= r_note - 1'b1;
        end else if (i_cmd.up_init) begin
            r_scan <= r_note + 1'b1;
        end else if (i_cmd.scan_dec) begin
            r_scan <= r_scan - 1'b1;
        end else if (i_cmd.scan_inc) begin
            r_scan <= r_scan + 1'b1;
        end
        // At the end of a scan with nothing found, the data reads zero.
        if (i_cmd.cap_lo) begin
            r_n1 <= r_scan;
            r_t1 <= rd_val;
        end
        if (i_cmd.cap_hi) begin
            r_n2 <= r_scan;
            r_t2 <= rd_val;
        end
        if (i_cmd.mul) begin
            r_prod <= x1 * diff;
            r_x2   <= r_n2 - r_n1;
        end
        if (i_cmd.div_start) begin
            r_neg <= r_prod[PROD_W-1];
            r_quo <= prod_abs[MAG_W-1:0];
            r_rem <= '0;
            r_cnt <= CNT_W'(MAG_W);
        end else if (i_cmd.div_step) begin
            r_quo <= {r_quo[MAG_W-2:0], q_bit};
            r_rem <= q_bit ? NOTE_W'(rem_sh - {1'b0, r_x2}) : rem_sh[NOTE_W-1:0];
            r_cnt <= r_cnt - 1'b1;
        end
    end

    assign wr_en   = (i_cmd.exec && exec_wr) || i_cmd.wr_interp;
    assign wr_data = i_cmd.wr_interp ? interp_val : exec_tune;

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_res_dac  <= exec_dac;
            r_res_tune <= exec_tune;
        end else if (i_cmd.wr_interp) begin
            r_res_dac  <= '0;
            r_res_tune <= interp_val;
        end
        if (i_cmd.out_load) begin
            r_out_dac  <= r_res_dac;
            r_out_tune <= r_res_tune;
        end
    end

    assign o_dac_code   = r_out_dac;
    assign o_tune_value = r_out_tune;

    assign o_sts.op        = r_op;
    assign o_sts.edge_note = (r_note == '0) || (r_note == NOTE_W'(NOTE_COUNT - 1));
    assign o_sts.rd_nz     = (rd_val != '0);
    assign o_sts.scan_lo   = (r_scan == '0);
    assign o_sts.scan_hi   = (r_scan == NOTE_W'(NOTE_COUNT - 1));
    assign o_sts.div_last  = (r_cnt == CNT_W'(1));
endmodule

// File: hdl/nttc_ctrl.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module nttc_ctrl
    import nttc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    output logic o_valid,
    input  logic i_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_RD     = 4'd1;
    localparam logic [3:0] S_EXEC   = 4'd2;
    localparam logic [3:0] S_DN_RD  = 4'd3;
    localparam logic [3:0] S_DN_CHK = 4'd4;
    localparam logic [3:0] S_UP_RD  = 4'd5;
    localparam logic [3:0] S_UP_CHK = 4'd6;
    localparam logic [3:0] S_MUL    = 4'd7;
    localparam logic [3:0] S_DIVS   = 4'd8;
    localparam logic [3:0] S_DIV    = 4'd9;
    localparam logic [3:0] S_WRI    = 4'd10;
    localparam logic [3:0] S_FIN    = 4'd11;

    logic [3:0] r_state, n_state;
    logic       r_ovld, n_ovld;
    logic       out_free;

    assign o_ready  = (r_state == S_IDLE);
    assign o_valid  = r_ovld;
    assign out_free = !r_ovld || i_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_RD;
                end
            end
            S_RD: begin
                o_cmd.rd_note = 1'b1;
                n_state       = S_EXEC;
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                if (i_sts.op == OP_INTERP && !i_sts.edge_note) begin
                    o_cmd.dn_init = 1'b1;
                    n_state       = S_DN_RD;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_DN_RD: begin
                o_cmd.rd_scan = 1'b1;
                n_state       = S_DN_CHK;
            end
            S_DN_CHK: begin
                if (i_sts.rd_nz || i_sts.scan_lo) begin
                    o_cmd.cap_lo  = 1'b1;
                    o_cmd.up_init = 1'b1;
                    n_state       = S_UP_RD;
                end else begin
                    o_cmd.scan_dec = 1'b1;
                    n_state        = S_DN_RD;
                end
            end
            S_UP_RD: begin
                o_cmd.rd_scan = 1'b1;
                n_state       = S_UP_CHK;
            end
            S_UP_CHK: begin
                if (i_sts.rd_nz || i_sts.scan_hi) begin
                    o_cmd.cap_hi = 1'b1;
                    n_state      = S_MUL;
                end else begin
                    o_cmd.scan_inc = 1'b1;
                    n_state        = S_UP_RD;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_DIVS;
            end
            S_DIVS: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_WRI;
                end
            end
            S_WRI: begin
                o_cmd.wr_interp = 1'b1;
                n_state         = S_FIN;
            end
            S_FIN: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_ovld = r_ovld;
        if (o_cmd.out_load) begin
            n_ovld = 1'b1;
        end else if (i_ready) begin
            n_ovld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ovld  <= n_ovld;
        end
    end

    `NTTC_ASSERT(a_accept_reads, i_clk, i_rst_n, (i_valid && o_ready) |=> (r_state == S_RD))
    `NTTC_NEVER(a_no_overwrite, i_clk, i_rst_n, o_cmd.out_load && r_ovld && !i_ready)
    `NTTC_ASSERT(a_valid_from_fin, i_clk, i_rst_n, $rose(r_ovld) |-> $past(r_state == S_FIN))
endmodule
